// ===== design/rct_pkg.sv =====
`timescale 1ns / 1ps

package rct_pkg;

	localparam int ID_W               = 16;
	localparam int STATUS_W           = 3;
	localparam int SLOT_OUT_W         = 5;
	// wide enough for the largest in-flight table (256 slots)
	localparam int SLOT_IDX_W         = 8;
	localparam int PENDING_DEPTH_DEF  = 16;
	localparam int INFLIGHT_DEPTH_DEF = 32;

	typedef logic [ID_W-1:0]       id_t;
	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
	typedef logic [SLOT_OUT_W-1:0] slot_out_t;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_QUEUED   = 3'd0,
		ST_INFLIGHT = 3'd1,
		ST_PENDING  = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_FLUSHED  = 3'd6
	} status_t;

	// request token that walks down the cell chain
	typedef struct packed {
		logic      vld;
		op_t       op;
		id_t       key;
		logic      hit;
		logic      pend_hit;
		slot_idx_t idx;
		logic      last;
	} tok_t;

endpackage

// ===== design/rct_pend_cell.sv =====
`timescale 1ns / 1ps

module rct_pend_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          shift,
	input  logic          wr_en,
	input  rct_pkg::id_t  wr_id,
	input  rct_pkg::id_t  nbr_id,
	input  logic          nbr_vld,
	input  rct_pkg::tok_t tok_in,
	output rct_pkg::tok_t tok_out,
	output rct_pkg::id_t  id,
	output logic          vld
);

	rct_pkg::id_t  id_q;
	logic          vld_q;
	rct_pkg::tok_t tok_q;
	rct_pkg::tok_t tok_nx;

	always_comb begin
		tok_nx = tok_in;
		if (tok_in.vld && tok_in.op == rct_pkg::OP_ADD && vld_q && id_q == tok_in.key) begin
			tok_nx.pend_hit = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q <= wr_id;
		end else if (shift) begin
			id_q <= nbr_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_q <= '0;
		end else begin
			if (wr_en) begin
				vld_q <= 1'b1;
			end else if (shift) begin
				vld_q <= nbr_vld;
			end
			if (adv) begin
				tok_q <= tok_nx;
			end
		end
	end

	assign tok_out = tok_q;
	assign id      = id_q;
	assign vld     = vld_q;

endmodule

// ===== design/rct_slot_cell.sv =====
`timescale 1ns / 1ps

module rct_slot_cell #(
	parameter int SLOT_IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  rct_pkg::tok_t tok_in,
	output rct_pkg::tok_t tok_out
);

	localparam rct_pkg::slot_idx_t CELL_IDX = rct_pkg::slot_idx_t'(SLOT_IDX);

	rct_pkg::id_t  entry_q;
	rct_pkg::id_t  entry_nx;
	logic          entry_wr;
	rct_pkg::tok_t tok_q;
	rct_pkg::tok_t tok_nx;

	always_comb begin
		tok_nx   = tok_in;
		entry_wr = 1'b0;
		entry_nx = entry_q;
		if (tok_in.vld && !tok_in.hit) begin
			unique case (tok_in.op)
				rct_pkg::OP_ADD: begin
					if (entry_q == tok_in.key) begin
						tok_nx.hit = 1'b1;
						tok_nx.idx = CELL_IDX;
					end
				end
				rct_pkg::OP_DEL: begin
					if (entry_q == tok_in.key) begin
						tok_nx.hit = 1'b1;
						tok_nx.idx = CELL_IDX;
						entry_wr   = 1'b1;
						entry_nx   = '0;
					end
				end
				rct_pkg::OP_FLUSH: begin
					// claim the first empty slot seen
					if (entry_q == '0) begin
						tok_nx.hit = 1'b1;
						tok_nx.idx = CELL_IDX;
						entry_wr   = 1'b1;
						entry_nx   = tok_in.key;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			tok_q   <= '0;
		end else if (adv) begin
			tok_q <= tok_nx;
			if (entry_wr) begin
				entry_q <= entry_nx;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== design/request_coalescing_tracker_top.sv =====
`timescale 1ns / 1ps

// channel  | valid     | stall     | payload
// ---------+-----------+-----------+--------------------------------------------
// in       | in_valid  | in_stall  | operation, player_id
// out      | out_valid | out_stall | status, out_id, slot_index, slot_granted, last
//
// A request walks a chain of PENDING_DEPTH list cells and INFLIGHT_DEPTH slot cells, one cell
// a cycle unless out_stall holds the chain; its result is then registered at the output.
// A flush injects one pending id a cycle straight into the slot chain, also held by out_stall;
// the next request is taken once the last result is registered.
// Reset clears the slot table and the list count at once; no clearing pass.
// out_stall freezes the whole chain until the output register is taken.
module request_coalescing_tracker_top #(
	parameter int PENDING_DEPTH  = rct_pkg::PENDING_DEPTH_DEF,
	parameter int INFLIGHT_DEPTH = rct_pkg::INFLIGHT_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic [rct_pkg::ID_W-1:0]         player_id,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rct_pkg::STATUS_W-1:0]     status,
	output logic [rct_pkg::ID_W-1:0]         out_id,
	output logic [rct_pkg::SLOT_OUT_W-1:0]   slot_index,
	output logic                             slot_granted,
	output logic                             last
);

	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(PENDING_DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	logic            busy_q;
	logic            flush_act_q;
	logic [CW-1:0]   pend_cnt_q;
	rct_pkg::tok_t   ent_q;
	logic            adv;
	logic            acc;
	logic            shift;
	logic            app;

	rct_pkg::tok_t   pend_tok [PENDING_DEPTH+1];
	rct_pkg::tok_t   slot_tok [INFLIGHT_DEPTH+1];
	rct_pkg::id_t    pend_id  [PENDING_DEPTH];
	logic            pend_vld [PENDING_DEPTH];
	rct_pkg::tok_t   inj_tok;
	rct_pkg::tok_t   ex;

	rct_pkg::status_t  ex_status;
	logic              out_vld_q;
	rct_pkg::status_t  status_q;
	rct_pkg::id_t      out_id_q;
	rct_pkg::slot_out_t slot_q;
	logic              gnt_q;
	logic              last_q;

	assign adv      = !out_vld_q || !out_stall;
	assign acc      = in_valid && !busy_q;
	assign in_stall = busy_q;
	assign shift    = adv && flush_act_q;

	assign pend_tok[0] = ent_q;
	assign ex          = slot_tok[INFLIGHT_DEPTH];

	always_comb begin
		inj_tok      = '0;
		inj_tok.vld  = 1'b1;
		inj_tok.op   = rct_pkg::OP_FLUSH;
		inj_tok.key  = pend_id[0];
		inj_tok.last = (pend_cnt_q == CNT_ONE);
	end

	assign slot_tok[0] = flush_act_q ? inj_tok : pend_tok[PENDING_DEPTH];

	assign app = adv && ex.vld && ex.op == rct_pkg::OP_ADD && !ex.hit && !ex.pend_hit
		&& pend_cnt_q != CNT_FULL;

	genvar k;
	generate
		for (k = 0; k < PENDING_DEPTH; k++) begin : g_pend
			rct_pkg::id_t nbr_id;
			logic         nbr_vld;
			if (k == PENDING_DEPTH - 1) begin : g_tail
				assign nbr_id  = '0;
				assign nbr_vld = 1'b0;
			end else begin : g_mid
				assign nbr_id  = pend_id[k+1];
				assign nbr_vld = pend_vld[k+1];
			end
			rct_pend_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.shift   (shift),
				.wr_en   (app && pend_cnt_q == CW'(k)),
				.wr_id   (ex.key),
				.nbr_id  (nbr_id),
				.nbr_vld (nbr_vld),
				.tok_in  (pend_tok[k]),
				.tok_out (pend_tok[k+1]),
				.id      (pend_id[k]),
				.vld     (pend_vld[k])
			);
		end
		for (k = 0; k < INFLIGHT_DEPTH; k++) begin : g_slot
			rct_slot_cell #(
				.SLOT_IDX (k)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.tok_in  (slot_tok[k]),
				.tok_out (slot_tok[k+1])
			);
		end
	endgenerate

	always_comb begin
		unique case (ex.op)
			rct_pkg::OP_ADD: begin
				priority if (ex.hit) ex_status = rct_pkg::ST_INFLIGHT;
				else if (ex.pend_hit) ex_status = rct_pkg::ST_PENDING;
				else if (pend_cnt_q == CNT_FULL) ex_status = rct_pkg::ST_FULL;
				else ex_status = rct_pkg::ST_QUEUED;
			end
			rct_pkg::OP_DEL: begin
				ex_status = ex.hit ? rct_pkg::ST_CLEARED : rct_pkg::ST_NOTFOUND;
			end
			default: begin
				ex_status = rct_pkg::ST_FLUSHED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			flush_act_q <= 1'b0;
			pend_cnt_q  <= '0;
			ent_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (acc) begin
				unique case (operation)
					rct_pkg::OP_ADD, rct_pkg::OP_DEL: begin
						ent_q  <= '{vld: 1'b1, op: rct_pkg::op_t'(operation),
							key: player_id, hit: 1'b0, pend_hit: 1'b0,
							idx: '0, last: 1'b1};
						busy_q <= 1'b1;
					end
					rct_pkg::OP_FLUSH: begin
						if (pend_cnt_q != '0) begin
							flush_act_q <= 1'b1;
							busy_q      <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else begin
				if (adv) begin
					ent_q.vld <= 1'b0;
				end
				if (adv && ex.vld && ex.last) begin
					busy_q <= 1'b0;
				end
			end
			// drain the list head into the slot chain
			if (shift) begin
				pend_cnt_q <= pend_cnt_q - CNT_ONE;
				if (pend_cnt_q == CNT_ONE) begin
					flush_act_q <= 1'b0;
				end
			end else if (app) begin
				pend_cnt_q <= pend_cnt_q + CNT_ONE;
			end
			if (adv) begin
				out_vld_q <= ex.vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ex.vld) begin
			status_q <= ex_status;
			out_id_q <= ex.key;
			slot_q   <= ex.hit ? rct_pkg::slot_out_t'(ex.idx) : '0;
			gnt_q    <= ex.op == rct_pkg::OP_FLUSH && ex.hit;
			last_q   <= ex.last;
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign slot_index   = slot_q;
	assign slot_granted = gnt_q;
	assign last         = last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= CNT_FULL)
		else $error("pending count beyond list depth");

	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		flush_act_q |-> busy_q && pend_cnt_q != '0)
		else $error("flush drain without busy or with empty list");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !(flush_act_q && $past(operation) != rct_pkg::OP_FLUSH))
		else $error("flush drain started by a non-flush request");

	a_grant_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && gnt_q |-> status_q == rct_pkg::ST_FLUSHED)
		else $error("slot granted on a non-flush result");

endmodule

// ===== tb/tb_request_coalescing_tracker_top.sv =====
`timescale 1ns / 1ps

module tb_request_coalescing_tracker_top;
	import rct_pkg::*;

	localparam int LIST_DEPTH = PENDING_DEPTH_DEF;
	localparam int SLOT_DEPTH = INFLIGHT_DEPTH_DEF;
	localparam int TOTAL_ITEMS = 450;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 120;
	localparam int DRAIN_LIMIT = 20000;
	localparam longint RUN_LIMIT_NS = 64'd12 * 64'd600_000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		status_t   st;
		id_t       id;
		slot_out_t slot;
		logic      granted;
		logic      lst;
	} result_t;

	typedef struct packed {
		logic [1:0] op;
		id_t        id;
		logic       typed;
		status_t    st;
		slot_out_t  slot;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	logic [1:0] operation;
	id_t       player_id;
	logic      out_valid;
	logic      out_stall;
	logic [STATUS_W-1:0] status;
	id_t       out_id;
	slot_out_t slot_index;
	logic      slot_granted;
	logic      last;

	// tracker state as the testbench sees it
	id_t list_ids [LIST_DEPTH];
	int  list_len;
	id_t slot_ids [SLOT_DEPTH];

	result_t step_q [$];
	result_t expected_q [$];

	int  errors;
	int  requests_taken;
	int  results_seen;
	int  status_hits [8];
	int  untracked_flushes;
	bit  sender_idle_on;
	bit  receiver_idle_on;
	bit  hold_output;

	// after reset: slot table empty, list empty
	dir_row_t dir_rows [24] = '{
		'{OP_ADD,    16'h0000, 1'b1, ST_INFLIGHT, 5'd0},
		'{OP_DEL,    16'h0000, 1'b1, ST_CLEARED,  5'd0},
		'{OP_DEL,    16'hFFFF, 1'b1, ST_NOTFOUND, 5'd0},
		'{OP_FLUSH,  16'h0000, 1'b0, ST_QUEUED,   5'd0},
		'{OP_UNUSED, 16'hABCD, 1'b0, ST_QUEUED,   5'd0},
		'{OP_ADD,    16'hFFFF, 1'b1, ST_QUEUED,   5'd0},
		'{OP_ADD,    16'hFFFF, 1'b1, ST_PENDING,  5'd0},
		'{OP_ADD,    16'h0001, 1'b1, ST_QUEUED,   5'd0},
		'{OP_ADD,    16'h8000, 1'b1, ST_QUEUED,   5'd0},
		'{OP_UNUSED, 16'h5555, 1'b0, ST_QUEUED,   5'd0},
		'{OP_FLUSH,  16'h1234, 1'b0, ST_QUEUED,   5'd0},
		'{OP_ADD,    16'hFFFF, 1'b1, ST_INFLIGHT, 5'd0},
		'{OP_ADD,    16'h8000, 1'b1, ST_INFLIGHT, 5'd2},
		'{OP_DEL,    16'h0001, 1'b1, ST_CLEARED,  5'd1},
		'{OP_ADD,    16'h0000, 1'b1, ST_INFLIGHT, 5'd1},
		'{OP_DEL,    16'h0000, 1'b1, ST_CLEARED,  5'd1},
		'{OP_ADD,    16'h2AAA, 1'b1, ST_QUEUED,   5'd0},
		'{OP_FLUSH,  16'hFFFF, 1'b0, ST_QUEUED,   5'd0},
		'{OP_DEL,    16'hFFFF, 1'b1, ST_CLEARED,  5'd0},
		'{OP_DEL,    16'hFFFF, 1'b1, ST_NOTFOUND, 5'd0},
		'{OP_ADD,    16'h5555, 1'b1, ST_QUEUED,   5'd0},
		'{OP_FLUSH,  16'h0000, 1'b0, ST_QUEUED,   5'd0},
		'{OP_FLUSH,  16'h0000, 1'b0, ST_QUEUED,   5'd0},
		'{OP_ADD,    16'h0000, 1'b1, ST_INFLIGHT, 5'd3}
	};

	request_coalescing_tracker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.player_id    (player_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_id       (out_id),
		.slot_index   (slot_index),
		.slot_granted (slot_granted),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: run did not finish in time", $time);
		$display("tb_request_coalescing_tracker_top: FAIL");
		$finish;
	end

	function automatic result_t mk_result(status_t st, id_t id, int s, logic g, logic l);
		result_t r;
		r.st = st;
		r.id = id;
		r.slot = (s < 0) ? '0 : slot_out_t'(s);
		r.granted = g;
		r.lst = l;
		return r;
	endfunction

	function automatic int lowest_slot(id_t key);
		for (int s = 0; s < SLOT_DEPTH; s++)
			if (slot_ids[s] == key)
				return s;
		return -1;
	endfunction

	// advance the tracker state by one request; results land in step_q
	task automatic track_request(logic [1:0] op, id_t id);
		int s;
		bit dup;
		step_q.delete();
		case (op)
		OP_ADD: begin
			s = lowest_slot(id);
			dup = 1'b0;
			for (int i = 0; i < list_len; i++)
				if (list_ids[i] == id)
					dup = 1'b1;
			if (s >= 0)
				step_q.push_back(mk_result(ST_INFLIGHT, id, s, 1'b0, 1'b1));
			else if (dup)
				step_q.push_back(mk_result(ST_PENDING, id, -1, 1'b0, 1'b1));
			else if (list_len >= LIST_DEPTH)
				step_q.push_back(mk_result(ST_FULL, id, -1, 1'b0, 1'b1));
			else begin
				list_ids[list_len] = id;
				list_len++;
				step_q.push_back(mk_result(ST_QUEUED, id, -1, 1'b0, 1'b1));
			end
		end
		OP_DEL: begin
			s = lowest_slot(id);
			if (s >= 0) begin
				slot_ids[s] = '0;
				step_q.push_back(mk_result(ST_CLEARED, id, s, 1'b0, 1'b1));
			end else
				step_q.push_back(mk_result(ST_NOTFOUND, id, -1, 1'b0, 1'b1));
		end
		OP_FLUSH: begin
			for (int i = 0; i < list_len; i++) begin
				// take the first empty slot; a flushed zero leaves it empty
				s = lowest_slot('0);
				if (s >= 0)
					slot_ids[s] = list_ids[i];
				step_q.push_back(mk_result(ST_FLUSHED, list_ids[i], s, s >= 0,
					i == list_len - 1));
			end
			list_len = 0;
		end
		default: ;
		endcase
	endtask

	// called at a clock edge; returns at the edge that takes the request
	task automatic offer_request(logic [1:0] op, id_t id, bit typed = 1'b0,
			result_t typed_res = '0);
		if (sender_idle_on && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		player_id <= id;
		do @(posedge clk); while (in_stall);
		requests_taken++;
		track_request(op, id);
		if (typed)
			expected_q.push_back(typed_res);
		else
			foreach (step_q[j])
				expected_q.push_back(step_q[j]);
	endtask

	function automatic id_t pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 55)
			return id_t'($urandom_range(1, 48));
		return id_t'($urandom_range(0, 65535));
	endfunction

	// a run of adds and deletes closed by a flush, with some noise mixed in
	task automatic random_burst();
		int n;
		int r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 80)
			n = $urandom_range(1, 6);
		else if (pick < 95)
			n = $urandom_range(7, 16);
		else
			n = $urandom_range(17, 20);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			// overflow the list with adds only
			if (n > LIST_DEPTH)
				offer_request(OP_ADD, id_t'($urandom_range(0, 65535)));
			else if (r < 70)
				offer_request(OP_ADD, pick_id());
			else if (r < 82)
				offer_request(OP_DEL, slot_ids[$urandom_range(SLOT_DEPTH - 1)]);
			else if (r < 90)
				offer_request(OP_DEL, pick_id());
			else if (r < 95)
				offer_request(OP_UNUSED, pick_id());
			else
				offer_request(OP_FLUSH, pick_id());
		end
		offer_request(OP_FLUSH, pick_id());
	endtask

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			status_hits[status]++;
			if (status == ST_FLUSHED && slot_granted === 1'b0)
				untracked_flushes++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result status %0d id %h", $time, status, out_id);
				errors++;
			end else begin
				want = expected_q.pop_front();
				compare_field("status", want.st, status);
				compare_field("out_id", want.id, out_id);
				compare_field("slot_index", want.slot, slot_index);
				compare_field("slot_granted", want.granted, slot_granted);
				compare_field("last", want.lst, last);
			end
		end
	end

	initial begin : receiver
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				// hold off long enough for the chain to back up into the input
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_output = 1'b0;
			end else
				out_stall <= receiver_idle_on && $urandom_range(99) < 8;
		end
	end

	initial begin : stimulus
		int drain;
		bit held;
		bit paused;
		errors = 0;
		requests_taken = 0;
		results_seen = 0;
		untracked_flushes = 0;
		foreach (status_hits[k])
			status_hits[k] = 0;
		foreach (slot_ids[s])
			slot_ids[s] = '0;
		list_len = 0;
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		hold_output = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_ADD;
		player_id <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			offer_request(dir_rows[k].op, dir_rows[k].id, dir_rows[k].typed,
				mk_result(dir_rows[k].st, dir_rows[k].id, dir_rows[k].slot, 1'b0, 1'b1));

		while (requests_taken < TOTAL_ITEMS) begin
			if (!held && requests_taken >= 100) begin
				hold_output = 1'b1;
				held = 1'b1;
			end
			if (!paused && requests_taken >= 250) begin
				// let the tracker run dry before going on
				in_valid <= 1'b0;
				do @(posedge clk); while (expected_q.size() != 0);
				paused = 1'b1;
			end
			sender_idle_on = !(requests_taken >= 300 && requests_taken < 400);
			receiver_idle_on = sender_idle_on;
			random_burst();
		end

		in_valid <= 1'b0;
		drain = 0;
		do begin
			@(posedge clk);
			drain++;
		end while (expected_q.size() != 0 && drain < DRAIN_LIMIT);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_q.size());
			errors += expected_q.size();
		end

		$display("%0d requests, %0d results: queued %0d, in flight %0d, pending %0d, full %0d",
			requests_taken, results_seen, status_hits[ST_QUEUED], status_hits[ST_INFLIGHT],
			status_hits[ST_PENDING], status_hits[ST_FULL]);
		$display("cleared %0d, not found %0d, flushed %0d (%0d with no free slot)",
			status_hits[ST_CLEARED], status_hits[ST_NOTFOUND], status_hits[ST_FLUSHED],
			untracked_flushes);
		if (errors == 0)
			$display("tb_request_coalescing_tracker_top: PASS");
		else
			$display("tb_request_coalescing_tracker_top: FAIL");
		$finish;
	end

endmodule

// ===== request_coalescing_tracker_top.f =====
design/rct_pkg.sv
design/rct_pend_cell.sv
design/rct_slot_cell.sv
design/request_coalescing_tracker_top.sv
tb/tb_request_coalescing_tracker_top.sv
